FILE: design/bcpg_pkg.sv
package bcpg_pkg;

  // Reading and converter geometry.
  localparam int SAMPLES_PER_READING = 10;
  localparam int ADC_BITS            = 12;
  localparam int SAMPLE_W            = 12;
  localparam int SUM_W               = 16;
  localparam int CNT_W               = 4;
  localparam int MV_W                = 16;
  localparam int PCT_W               = 7;

  // Only the low ADC_BITS bits of a sample carry the reading.
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // Mean by reciprocal multiplication: ceil(2^20 / N) gives the exact floor
  // for every 16-bit sum when N is at most 16.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int AVG_PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) /
             64'(SAMPLES_PER_READING));

  // Serial divider: 25-bit dividend covers 4200 * 4095, 12-bit divisor.
  localparam int DIV_W     = 25;
  localparam int DEN_W     = 12;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DEN_W-1:0] REF_COUNT_RESET = DEN_W'(2280);
  localparam logic [12:0]      FULL_SCALE_MV   = 13'd4200;

  // Lithium discharge curve: breakpoints in mV and their charge in percent.
  localparam int NUM_BP = 12;
  localparam int SEG_W  = 4;
  localparam logic [MV_W-1:0] BP_MV [NUM_BP] = '{
    16'd3000, 16'd3300, 16'd3600, 16'd3700, 16'd3750, 16'd3790,
    16'd3830, 16'd3870, 16'd3920, 16'd3970, 16'd4100, 16'd4200
  };
  localparam logic [PCT_W-1:0] BP_PCT [NUM_BP] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // Microcode.
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_TAKE,
    OP_AVG,
    OP_DIV,
    OP_LOAD_MV,
    OP_SAT,
    OP_SEG,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_FINAL,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Program: a taken jump goes to target, otherwise the next step follows.
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      3'd0:    w = '{op: OP_TAKE,    cond: COND_NO_FINAL, target: 3'd0};
      3'd1:    w = '{op: OP_AVG,     cond: COND_NEVER,    target: 3'd0};
      3'd2:    w = '{op: OP_LOAD_MV, cond: COND_NEVER,    target: 3'd0};
      3'd3:    w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: 3'd3};
      3'd4:    w = '{op: OP_SAT,     cond: COND_NEVER,    target: 3'd0};
      3'd5:    w = '{op: OP_SEG,     cond: COND_NEVER,    target: 3'd0};
      3'd6:    w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: 3'd6};
      3'd7:    w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: 3'd7};
      default: w = '{op: OP_TAKE,    cond: COND_NO_FINAL, target: 3'd0};
    endcase
    return w;
  endfunction

  // Width of the curve segment that starts at a breakpoint.
  function automatic logic [DEN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] d;
    d = BP_MV[seg + SEG_W'(1)] - BP_MV[seg];
    return d[DEN_W-1:0];
  endfunction

  // Percentage gained across the segment that starts at a breakpoint.
  function automatic logic [3:0] seg_rise(input logic [SEG_W-1:0] seg);
    logic [PCT_W-1:0] d;
    d = BP_PCT[seg + SEG_W'(1)] - BP_PCT[seg];
    return d[3:0];
  endfunction

endpackage

FILE: design/battery_charge_percent_gauge_unit.sv
// Battery charge gauge.
// Input channel: one 12-bit converter sample per beat on sample_i, with
// in_valid_i / in_stall_o. Every SAMPLES_PER_READING samples form one reading.
// Output channel: one beat per reading carrying the truncated mean
// (average_count_o), the cell voltage floor(4200 * mean / ref_count) saturated
// at 65535 (millivolts_o), and the state of charge from a twelve-point
// lithium curve (percent_o), with out_valid_o / out_stall_i.
// Configuration: cfg_we_i writes cfg_ref_count_i, the mean count of a full
// 4.2 V cell, at once; write it only while the block is idle.
// Timing: samples that do not close a reading are taken one per cycle. The
// closing sample starts a microcoded program: a reciprocal multiply for the
// mean, then one shared restoring divider run twice (voltage, curve
// interpolation). The input is stalled from the closing sample until the
// result beat is loaded into the output register.
// While the receiver stalls, the result is held in the output register and
// new samples are still taken; only the next reading's finish waits for it.
// Reset clears the running sum and count, restores ref_count to 2280 and
// empties the output register.
module battery_charge_percent_gauge_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bcpg_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bcpg_pkg::SAMPLE_W-1:0] average_count_o,
  output logic [bcpg_pkg::MV_W-1:0]     millivolts_o,
  output logic [bcpg_pkg::PCT_W-1:0]    percent_o,
  input  logic                          cfg_we_i,
  input  logic [bcpg_pkg::DEN_W-1:0]    cfg_ref_count_i
);
  import bcpg_pkg::*;

  // Sequencer and control state.
  logic [STEP_W-1:0]    step_q, step_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DEN_W-1:0]     ref_q;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;

  // Datapath registers.
  logic [DIV_W-1:0]    quo_q, quo_d;
  logic [DEN_W-1:0]    rem_q, rem_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [SAMPLE_W-1:0] avg_q, avg_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [SEG_W-1:0]    seg_q, seg_d;
  logic                hi_q, hi_d;
  logic                lo_q, lo_d;
  logic [SAMPLE_W-1:0] out_avg_q, out_avg_d;
  logic [MV_W-1:0]     out_mv_q, out_mv_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;

  // Intermediate logic.
  ctrl_t               ctrl;
  logic [SAMPLE_W-1:0] smp;
  logic                in_beat;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W:0]      taken;
  logic                last;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      trial_sub;
  logic                trial_ge;
  logic [SEG_W-1:0]    seg_sel;
  logic [MV_W-1:0]     seg_diff;
  logic [12:0]         seg_num;
  logic                out_free;
  logic                jump;

  assign ctrl       = ucode_rom(step_q);
  assign in_stall_o = (ctrl.op != OP_TAKE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign smp        = sample_i & SAMPLE_MASK;
  assign sum_next   = sum_q + SUM_W'(smp);
  assign taken      = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign last       = (taken >= (CNT_W+1)'(SAMPLES_PER_READING));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Mean of the finished reading: the sum times the reciprocal of the count.
  assign avg_prod = AVG_PROD_W'(quo_q[SUM_W-1:0]) * AVG_PROD_W'(AVG_RECIP);

  // One restoring division step: shift in the next dividend bit and try
  // to subtract the divisor.
  assign trial     = {rem_q, quo_q[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign trial_ge  = (trial >= {1'b0, den_q});

  // Highest inner breakpoint at or below the voltage picks the segment.
  always_comb begin
    seg_sel = SEG_W'(1);
    for (int i = 2; i < NUM_BP - 1; i++) begin
      if (mv_q >= BP_MV[i]) begin
        seg_sel = SEG_W'(i);
      end
    end
  end
  assign seg_diff = mv_q - BP_MV[seg_sel];
  assign seg_num  = 13'(seg_diff[8:0]) * 13'(seg_rise(seg_sel));

  // Jump condition of the current control word.
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_FINAL: jump = !(in_beat && last);
      COND_DIV_MORE: jump = (div_cnt_q != DIV_CNT_W'(DIV_STEPS - 1));
      COND_OUT_BUSY: jump = !out_free;
      default:       jump = 1'b0;
    endcase
  end

  // Datapath actions of the current control word.
  always_comb begin
    step_d      = jump ? ctrl.target : step_q + STEP_W'(1);
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    div_cnt_d   = div_cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    avg_d       = avg_q;
    mv_d        = mv_q;
    seg_d       = seg_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_avg_d   = out_avg_q;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;

    case (ctrl.op)
      OP_TAKE: begin
        if (in_beat) begin
          if (last) begin
            sum_d = '0;
            cnt_d = '0;
            quo_d = DIV_W'(sum_next);
          end else begin
            sum_d = sum_next;
            cnt_d = taken[CNT_W-1:0];
          end
        end
      end
      OP_AVG: begin
        avg_d = avg_prod[RECIP_SHIFT +: SAMPLE_W];
      end
      OP_DIV: begin
        quo_d     = {quo_q[DIV_W-2:0], trial_ge};
        rem_d     = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      OP_LOAD_MV: begin
        quo_d     = DIV_W'(avg_q) * DIV_W'(FULL_SCALE_MV);
        rem_d     = '0;
        den_d     = ref_q;
        div_cnt_d = '0;
      end
      OP_SAT: begin
        mv_d = (|quo_q[DIV_W-1:MV_W]) ? {MV_W{1'b1}} : quo_q[MV_W-1:0];
      end
      OP_SEG: begin
        hi_d      = (mv_q >= BP_MV[NUM_BP-1]);
        lo_d      = (mv_q < BP_MV[1]);
        seg_d     = seg_sel;
        quo_d     = DIV_W'(seg_num);
        rem_d     = '0;
        den_d     = seg_span(seg_sel);
        div_cnt_d = '0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_avg_d   = avg_q;
          out_mv_d    = mv_q;
          if (hi_q) begin
            out_pct_d = PCT_FULL;
          end else if (lo_q) begin
            out_pct_d = PCT_EMPTY;
          end else begin
            out_pct_d = BP_PCT[seg_q] + quo_q[PCT_W-1:0];
          end
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      ref_q       <= REF_COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ref_q <= cfg_ref_count_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    avg_q     <= avg_d;
    mv_q      <= mv_d;
    seg_q     <= seg_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    out_avg_q <= out_avg_d;
    out_mv_q  <= out_mv_d;
    out_pct_q <= out_pct_d;
  end

  assign out_valid_o     = out_valid_q;
  assign average_count_o = out_avg_q;
  assign millivolts_o    = out_mv_q;
  assign percent_o       = out_pct_q;

endmodule

FILE: design/bcpg_checker.sv
module bcpg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bcpg_pkg::SAMPLE_W-1:0] average_count_o,
  input logic [bcpg_pkg::MV_W-1:0]     millivolts_o,
  input logic [bcpg_pkg::PCT_W-1:0]    percent_o
);
  import bcpg_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(average_count_o) && $stable(millivolts_o) && $stable(percent_o))
    else $error("result payload changed while stalled");

  // Charge never exceeds a full cell.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_o <= PCT_FULL)
    else $error("charge above full");

  // At or above the top breakpoint the cell reads full.
  a_pct_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && millivolts_o >= BP_MV[NUM_BP-1] |-> percent_o == PCT_FULL)
    else $error("full cell not reported as full");

  // Below the first inner breakpoint the cell reads empty.
  a_pct_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && millivolts_o < BP_MV[1] |-> percent_o == PCT_EMPTY)
    else $error("low cell not reported as empty");

endmodule

bind battery_charge_percent_gauge_unit bcpg_checker u_bcpg_checker (.*);

FILE: sim/battery_charge_percent_gauge_unit_tb.sv
module battery_charge_percent_gauge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcpg_pkg::*;

  localparam int CFG_KEEP           = -1;
  localparam int SETTLE_CYCLES      = 100;
  localparam int QUIET_LIMIT        = 4000;
  localparam int READINGS_PER_PHASE = 20;
  localparam int RANDOM_PHASES      = 7;
  localparam int MAX_PRINTED_ERRORS = 50;
  localparam int unsigned FULL_CELL_MV     = 4200;
  localparam int unsigned MV_CEILING       = 65535;
  localparam int unsigned REF_AFTER_RESET  = 2280;
  localparam int unsigned SAMPLE_TOP       = 4095;

  // Discharge curve knees and the charge at each of them.
  localparam int unsigned KNEE_MV [12] = '{
    3000, 3300, 3600, 3700, 3750, 3790, 3830, 3870, 3920, 3970, 4100, 4200
  };
  localparam int unsigned KNEE_PCT [12] = '{
    0, 5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
  };

  // Reference settings of the random phases; the last two are drawn at random.
  localparam int unsigned PHASE_REF [5] = '{4095, 2100, 1, 0, 2280};

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic [MV_W-1:0]     mv;
    logic [PCT_W-1:0]    pct;
  } reading_t;

  typedef struct packed {
    int                  cfg;
    logic [SAMPLE_W-1:0] smp;
    int                  reps;
    bit                  typed;
    reading_t            want;
  } dir_row_t;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_HEAVY} rx_mode_e;

  // Directed readings: an empty cell, a zero reference at full scale, and a
  // voltage that lands exactly on the 3830 mV knee (reference 2100 doubles
  // the average). The typed result belongs to the beat that closes a reading.
  dir_row_t dir_rows [5] = '{
    '{CFG_KEEP, 12'd0,    10, 1'b1, '{12'd0,    16'd0,     7'd0}},
    '{0,        12'd4095, 10, 1'b1, '{12'd4095, 16'd65535, 7'd100}},
    '{2100,     12'd1915, 8,  1'b0, '{12'd0,    16'd0,     7'd0}},
    '{CFG_KEEP, 12'd1900, 1,  1'b0, '{12'd0,    16'd0,     7'd0}},
    '{CFG_KEEP, 12'd1930, 1,  1'b1, '{12'd1915, 16'd3830,  7'd50}}
  };

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic [SAMPLE_W-1:0] sample_i        = '0;
  logic                out_stall_i     = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [DEN_W-1:0]    cfg_ref_count_i = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [SAMPLE_W-1:0] average_count_o;
  logic [MV_W-1:0]     millivolts_o;
  logic [PCT_W-1:0]    percent_o;

  // Gauge state as the checker sees it.
  logic [SUM_W-1:0] acc_sum     = '0;
  logic [CNT_W-1:0] acc_count   = '0;
  logic [DEN_W-1:0] ref_setting = DEN_W'(REF_AFTER_RESET);
  reading_t         pending_readings [$];
  int               error_count  = 0;
  int               burst_left   = 0;
  int               quiet_cycles = 0;
  rx_mode_e         rx_mode      = RX_FREE;
  int               rx_mode_left = 0;

  battery_charge_percent_gauge_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .out_valid_o,
    .out_stall_i,
    .average_count_o,
    .millivolts_o,
    .percent_o,
    .cfg_we_i,
    .cfg_ref_count_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED_ERRORS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // State of charge from the curve; the bottom segment reads as empty.
  function automatic logic [PCT_W-1:0] curve_percent(input int unsigned mv);
    int k;
    if (mv >= KNEE_MV[11]) begin
      return PCT_W'(100);
    end
    if (mv < KNEE_MV[1]) begin
      return PCT_W'(0);
    end
    for (k = 10; k >= 1; k--) begin
      if (mv >= KNEE_MV[k]) begin
        return PCT_W'(KNEE_PCT[k] + (mv - KNEE_MV[k]) * (KNEE_PCT[k+1] - KNEE_PCT[k])
                      / (KNEE_MV[k+1] - KNEE_MV[k]));
      end
    end
    return PCT_W'(0);
  endfunction

  // Adds one sample to the running reading; the closing sample yields a result.
  task automatic take_sample(input logic [SAMPLE_W-1:0] smp, output bit closes,
                             output reading_t r);
    int unsigned avg;
    int unsigned q;
    acc_sum = acc_sum + SUM_W'(smp & SAMPLE_MASK);
    closes  = 1'b0;
    r       = '0;
    if (int'(acc_count) + 1 < SAMPLES_PER_READING) begin
      acc_count = acc_count + 1'b1;
      return;
    end
    avg       = int'(acc_sum) / SAMPLES_PER_READING;
    acc_sum   = '0;
    acc_count = '0;
    if (ref_setting == '0) begin
      q = MV_CEILING;
    end else begin
      q = (FULL_CELL_MV * avg) / int'(ref_setting);
      if (q > MV_CEILING) q = MV_CEILING;
    end
    r.avg  = SAMPLE_W'(avg);
    r.mv   = MV_W'(q);
    r.pct  = curve_percent(q);
    closes = 1'b1;
  endtask

  // Presents one beat and holds it until it is taken.
  task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input bit use_typed,
                           input reading_t typed_want);
    bit       closes;
    reading_t r;
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    take_sample(smp, closes, r);
    if (closes) pending_readings.push_back(use_typed ? typed_want : r);
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap        = $urandom_range(1, 12);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 15);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // The reference is changed only once the gauge has gone quiet.
  task automatic write_ref_count(input logic [DEN_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_ref_count_i <= value;
    @(posedge clk_i);
    ref_setting = value;
    cfg_we_i <= 1'b0;
  endtask

  // One reading: mostly samples clustered around an average that lands on a
  // knee of the curve or at a random voltage, sometimes plain noise.
  task automatic send_reading(input logic [DEN_W-1:0] refc);
    int unsigned mv_goal;
    int unsigned centre;
    int unsigned jit;
    int unsigned d;
    int unsigned s;
    int          j;
    d = 0;
    if ($urandom_range(0, 9) == 0) begin
      for (j = 0; j < SAMPLES_PER_READING; j++) begin
        send_beat(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'b0, '0);
        sender_pause();
      end
      return;
    end
    mv_goal = $urandom_range(0, 1) ? KNEE_MV[$urandom_range(0, 11)] : $urandom_range(2800, 4400);
    centre  = (mv_goal * int'(refc) + FULL_CELL_MV - 1) / FULL_CELL_MV;
    if (centre > SAMPLE_TOP) centre = SAMPLE_TOP;
    jit = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
    for (j = 0; j < SAMPLES_PER_READING; j++) begin
      if (j % 2 == 0) begin
        d = $urandom_range(0, jit);
        s = (centre + d > SAMPLE_TOP) ? SAMPLE_TOP : centre + d;
      end else begin
        s = (centre >= d) ? centre - d : 0;
      end
      send_beat(SAMPLE_W'(s), 1'b0, '0);
      sender_pause();
    end
  endtask

  // Receiver stall pattern: free-running, choppy and heavy stretches.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(20, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_FREE: begin
        out_stall_i <= 1'b0;
      end
      RX_CHOPPY: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // Check each result beat against the oldest expected reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        flag_error($sformatf("unexpected result beat: avg %0d mv %0d pct %0d",
                             average_count_o, millivolts_o, percent_o));
      end else begin
        want = pending_readings.pop_front();
        if (average_count_o !== want.avg)
          flag_error($sformatf("average_count got %0d expected %0d", average_count_o, want.avg));
        if (millivolts_o !== want.mv)
          flag_error($sformatf("millivolts got %0d expected %0d", millivolts_o, want.mv));
        if (percent_o !== want.pct)
          flag_error($sformatf("percent got %0d expected %0d", percent_o, want.pct));
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("battery_charge_percent_gauge_unit test failed");
      $finish;
    end
  end

  initial begin
    int              r;
    int              k;
    int              p;
    logic [DEN_W-1:0] phase_ref;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (r = 0; r < $size(dir_rows); r++) begin
      if (dir_rows[r].cfg != CFG_KEEP) write_ref_count(DEN_W'(dir_rows[r].cfg));
      for (k = 0; k < dir_rows[r].reps; k++) begin
        send_beat(dir_rows[r].smp, dir_rows[r].typed && (k == dir_rows[r].reps - 1),
                  dir_rows[r].want);
        sender_pause();
      end
    end

    // Random phases, each under its own reference; a partial reading may
    // carry over into the next phase.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      phase_ref = (p < $size(PHASE_REF)) ? DEN_W'(PHASE_REF[p])
                                         : DEN_W'($urandom_range(1, SAMPLE_TOP));
      write_ref_count(phase_ref);
      repeat (READINGS_PER_PHASE) send_reading(phase_ref);
      repeat ($urandom_range(0, SAMPLES_PER_READING - 1)) begin
        send_beat(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'b0, '0);
        sender_pause();
      end
    end

    // Drain the remaining results, then let the gauge settle.
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("battery_charge_percent_gauge_unit test passed");
    end else begin
      $display("battery_charge_percent_gauge_unit test failed");
    end
    $finish;
  end

endmodule
